FILE: design/sme_pkg.sv
// Shared types and constants of the stereo multi-tap echo.
package sme_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 19;
  localparam int GAIN_BITS      = 16;
  localparam int DELAY_BITS     = 19;
  localparam int REPEAT_BITS    = 5;
  localparam int FRAC           = 15;
  localparam int ROUND          = 16384;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LEFT_GAIN     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RIGHT_GAIN    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_SAMPLES = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FADE          = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REPEATS       = 3'd4;

  localparam logic [GAIN_BITS-1:0]   RST_GAIN    = 16'd16384;
  localparam logic [DELAY_BITS-1:0]  RST_DELAY   = 19'd9600;
  localparam logic [GAIN_BITS-1:0]   RST_FADE    = 16'd22938;
  localparam logic [REPEAT_BITS-1:0] RST_REPEATS = 5'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAPS,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic hit;
  } lane_ctl_t;

endpackage

FILE: design/stereo_multitap_echo.sv
// Top level of the stereo multi-tap echo: configuration, two channel lanes, output register.
//
// Each accepted stereo word is written into two delay memories, then the taps are read back
// one per cycle through the single read port of each lane's memory, both channels side by
// side. A word passes through an accept cycle, the taps with repeats clamped to 1..MAX_TAPS,
// a drain while the read and multiply stages empty into the accumulator, and a final step
// that rounds and loads the output register. The load waits while the output register
// still holds an untaken word; the next word is accepted in the cycle after the load while
// the result waits in the output register. No clearing pass runs after reset: the write
// pointer and a wrap flag mark which entries hold data, and unwritten entries count as zero.
module stereo_multitap_echo #(
  parameter int DEPTH       = 524288,
  parameter int MAX_TAPS    = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_en,
  input  logic [sme_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [sme_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // left_sample, right_sample
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // left_out, right_out
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     m_tdata
);

  localparam int PW  = $clog2(DEPTH);
  localparam int SB  = SAMPLE_BITS;
  localparam int TDW = ((2 * SB + 7) / 8) * 8;
  localparam int GB  = sme_pkg::GAIN_BITS;

  logic [GB-1:0]                     left_gain;
  logic [GB-1:0]                     right_gain;
  logic [sme_pkg::DELAY_BITS-1:0]    delay_samples;
  logic [GB-1:0]                     fade;
  logic [sme_pkg::REPEAT_BITS-1:0]   repeats;

  sme_pkg::lane_ctl_t ctl;
  logic [PW-1:0]      wpos;
  logic [PW-1:0]      rd_addr;
  logic               load_out;
  logic               out_free;
  logic               left_busy;
  logic               right_busy;
  logic signed [SB-1:0] left_res;
  logic signed [SB-1:0] right_res;
  logic [SB-1:0]      left_out;
  logic [SB-1:0]      right_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_gain     <= sme_pkg::RST_GAIN;
      right_gain    <= sme_pkg::RST_GAIN;
      delay_samples <= sme_pkg::RST_DELAY;
      fade          <= sme_pkg::RST_FADE;
      repeats       <= sme_pkg::RST_REPEATS;
    end else if (cfg_en) begin
      case (cfg_index)
        sme_pkg::REG_LEFT_GAIN:     left_gain     <= cfg_data[GB-1:0];
        sme_pkg::REG_RIGHT_GAIN:    right_gain    <= cfg_data[GB-1:0];
        sme_pkg::REG_DELAY_SAMPLES: delay_samples <= cfg_data[sme_pkg::DELAY_BITS-1:0];
        sme_pkg::REG_FADE:          fade          <= cfg_data[GB-1:0];
        sme_pkg::REG_REPEATS:       repeats       <= cfg_data[sme_pkg::REPEAT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !m_tvalid || m_tready;

  sme_ctrl #(
    .DEPTH    (DEPTH),
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .out_free      (out_free),
    .pipe_busy     (left_busy | right_busy),
    .delay_samples (delay_samples),
    .repeats       (repeats),
    .in_ready      (s_tready),
    .load_out      (load_out),
    .ctl           (ctl),
    .wpos          (wpos),
    .rd_addr       (rd_addr)
  );

  sme_lane #(
    .DEPTH       (DEPTH),
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_left (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .wr_addr (wpos),
    .rd_addr (rd_addr),
    .sample  ($signed(s_tdata[SB-1:0])),
    .gain    (left_gain),
    .fade    (fade),
    .busy    (left_busy),
    .result  (left_res)
  );

  sme_lane #(
    .DEPTH       (DEPTH),
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_right (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .wr_addr (wpos),
    .rd_addr (rd_addr),
    .sample  ($signed(s_tdata[2*SB-1:SB])),
    .gain    (right_gain),
    .fade    (fade),
    .busy    (right_busy),
    .result  (right_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      left_out  <= left_res;
      right_out <= right_res;
    end
  end

  assign m_tdata = TDW'({right_out, left_out});

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!m_tvalid || m_tready))
    else $error("output register loaded while holding an untaken word");

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word accepted before the first finished");

  a_load_shows_result: assert property (@(posedge clk) disable iff (rst)
    load_out |=> m_tvalid)
    else $error("finished word not presented on the output");

endmodule

FILE: design/sme_lane.sv
// One channel lane: delay memory, weight recursion, tap multiply-accumulate and rounding.
module sme_lane #(
  parameter int DEPTH       = 524288,
  parameter int MAX_TAPS    = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sme_pkg::lane_ctl_t                   ctl,
  input  logic [$clog2(DEPTH)-1:0]             wr_addr,
  input  logic [$clog2(DEPTH)-1:0]             rd_addr,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic [sme_pkg::GAIN_BITS-1:0]        gain,
  input  logic [sme_pkg::GAIN_BITS-1:0]        fade,
  output logic                                 busy,
  output logic signed [SAMPLE_BITS-1:0]        result
);

  localparam int GB   = sme_pkg::GAIN_BITS;
  localparam int PRW  = SAMPLE_BITS + GB + 1;
  localparam int ACCW = PRW + $clog2(MAX_TAPS + 1) + 1;
  localparam int WPW  = 2 * GB + 1;

  localparam logic signed [ACCW-1:0] RND = ACCW'(sme_pkg::ROUND);
  localparam logic signed [ACCW-1:0] HI  = ACCW'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [ACCW-1:0] LO  = ~HI;

  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rdata;

  logic [GB-1:0]           w;
  logic [GB-1:0]           w_next;
  logic [WPW-1:0]          wprod;
  logic [WPW-1-sme_pkg::FRAC:0] wsh;

  logic                    s1_valid;
  logic                    s1_hit;
  logic [GB-1:0]           s1_w;
  logic                    s2_valid;
  logic                    s2_hit;
  logic signed [PRW-1:0]   prod;
  logic signed [ACCW-1:0]  acc;
  logic signed [ACCW-1:0]  x;
  logic signed [ACCW-1:0]  q;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mem[wr_addr] <= sample;
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    wprod  = WPW'(w) * WPW'(fade) + WPW'(sme_pkg::ROUND);
    wsh    = wprod[WPW-1:sme_pkg::FRAC];
    w_next = (|wsh[WPW-1-sme_pkg::FRAC:GB]) ? {GB{1'b1}} : wsh[GB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= ctl.issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      w <= gain;
    end else if (ctl.issue) begin
      w <= w_next;
    end
    s1_hit <= ctl.hit;
    s1_w   <= w;
    s2_hit <= s1_hit;
    prod   <= rdata * $signed({1'b0, s1_w});
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc <= ACCW'(sample) <<< sme_pkg::FRAC;
    end else if (s2_valid && s2_hit) begin
      acc <= acc + ACCW'(prod);
    end
  end

  always_comb begin
    x = acc + RND;
    q = x >>> sme_pkg::FRAC;
    if (q > HI) begin
      result = HI[SAMPLE_BITS-1:0];
    end else if (q < LO) begin
      result = LO[SAMPLE_BITS-1:0];
    end else begin
      result = q[SAMPLE_BITS-1:0];
    end
  end

  assign busy = s1_valid | s2_valid;

endmodule

FILE: design/sme_ctrl.sv
// Tap sequencer: write pointer, fill tracking, tap offsets and read addresses.
module sme_ctrl #(
  parameter int DEPTH    = 524288,
  parameter int MAX_TAPS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               out_free,
  input  logic                               pipe_busy,
  input  logic [sme_pkg::DELAY_BITS-1:0]     delay_samples,
  input  logic [sme_pkg::REPEAT_BITS-1:0]    repeats,
  output logic                               in_ready,
  output logic                               load_out,
  output sme_pkg::lane_ctl_t                 ctl,
  output logic [$clog2(DEPTH)-1:0]           wpos,
  output logic [$clog2(DEPTH)-1:0]           rd_addr
);

  localparam int PW   = $clog2(DEPTH);
  localparam int TW   = $clog2(MAX_TAPS + 1);
  localparam int OFFW = PW + TW + 1;

  sme_pkg::state_t state;
  sme_pkg::state_t state_next;

  logic            wrapped;
  logic [OFFW-1:0] dreg;
  logic [OFFW-1:0] off;
  logic [TW-1:0]   tleft;
  logic [OFFW-1:0] dclamp;
  logic [TW-1:0]   nclamp;
  logic [OFFW-1:0] wpos_x;
  logic [OFFW-1:0] diff;
  logic [OFFW-1:0] wrapd;
  logic            in_range;
  logic            written;
  logic            accept;
  logic            last_tap;

  always_comb begin
    if (32'(delay_samples) > 32'(DEPTH - 1)) begin
      dclamp = OFFW'(DEPTH - 1);
    end else begin
      dclamp = OFFW'(delay_samples);
    end
    if (repeats == '0) begin
      nclamp = TW'(1);
    end else if (32'(repeats) > 32'(MAX_TAPS)) begin
      nclamp = TW'(MAX_TAPS);
    end else begin
      nclamp = TW'(repeats);
    end
  end

  always_comb begin
    wpos_x   = OFFW'(wpos);
    diff     = wpos_x - off;
    wrapd    = wpos_x + OFFW'(DEPTH) - off;
    rd_addr  = (wpos_x >= off) ? diff[PW-1:0] : wrapd[PW-1:0];
    in_range = off <= OFFW'(DEPTH - 1);
    written  = wrapped || (rd_addr <= wpos);
    last_tap = tleft == TW'(1);
  end

  always_comb begin
    state_next = state;
    case (state)
      sme_pkg::ST_IDLE: begin
        if (in_valid) state_next = sme_pkg::ST_TAPS;
      end
      sme_pkg::ST_TAPS: begin
        if (last_tap) state_next = sme_pkg::ST_DRAIN;
      end
      sme_pkg::ST_DRAIN: begin
        if (!pipe_busy) state_next = sme_pkg::ST_FINISH;
      end
      sme_pkg::ST_FINISH: begin
        if (out_free) state_next = sme_pkg::ST_IDLE;
      end
      default: state_next = sme_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = state == sme_pkg::ST_IDLE;
    accept    = in_ready && in_valid;
    load_out  = (state == sme_pkg::ST_FINISH) && out_free;
    ctl.start = accept;
    ctl.issue = state == sme_pkg::ST_TAPS;
    ctl.hit   = in_range && written;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= sme_pkg::ST_IDLE;
      wpos    <= '0;
      wrapped <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        if (wpos == PW'(DEPTH - 1)) begin
          wpos    <= '0;
          wrapped <= 1'b1;
        end else begin
          wpos <= wpos + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dreg  <= dclamp;
      off   <= dclamp;
      tleft <= nclamp;
    end else if (ctl.issue) begin
      off   <= off + dreg;
      tleft <= tleft - TW'(1);
    end
  end

  a_accept_starts_taps: assert property (@(posedge clk) disable iff (rst)
    accept |=> ctl.issue)
    else $error("accepted word did not start the tap sequence");

  a_last_tap_fills_pipe: assert property (@(posedge clk) disable iff (rst)
    ctl.issue && last_tap |=> pipe_busy)
    else $error("last tap did not enter the lane pipeline");

endmodule
